// ===== hdl/crcfd_pkg.sv =====
// Shared constants, types and the byte-wide CRC update of the frame deframer.
package crcfd_pkg;

	// Sync pair that opens every frame.
	localparam logic [7:0] SYNC_FIRST = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;

	// Reflected CRC-16 polynomial and bit steps taken per byte.
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam int CRC_BITS = 8;

	// Reset value of the payload length limit.
	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	// Configuration port geometry and register index.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_MAX_LEN = 1'b0;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Frame status codes.
	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_CRC_BAD = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Operations that the front hands to the back.
	typedef enum logic [2:0] {
		OP_SYNC = 3'd0,
		OP_FEED = 3'd1,
		OP_DATA = 3'd2,
		OP_ABORT = 3'd3,
		OP_CRC_LO = 3'd4,
		OP_CHECK = 3'd5
	} op_t;

	// One classified byte with the frame header it belongs to.
	typedef struct packed {
		op_t op;
		logic [7:0] rx_val;
		logic [7:0] command;
		logic [15:0] length;
	} rec_t;

	// One byte through the reflected CRC, eight bit steps unrolled.
	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < CRC_BITS; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// CRC after the sync pair, seen from a zero start.
	localparam logic [15:0] CRC_AFTER_SYNC = crc_feed(crc_feed(16'h0000, SYNC_FIRST), SYNC_SECOND);

endpackage

// ===== hdl/crc_frame_deframer_core.sv =====
// Top level of the frame deframer: config register, front, queue and back.
// A payload or closing result reaches the result ports through the queue and the result
// register, and can wait in the queue while the result register is full.
// Throughput: one byte per cycle while the queue has room; the four-entry queue decouples
// parsing from result pops, and a stalled reader backs up once the queue holds four records.
// Reset (arst_n low, asynchronous): hunting for sync, queue and result empty, CRC zero.
// The length limit resets to 1024.
module crc_frame_deframer_core import crcfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        data,
	output logic [7:0]        frame_command,
	output logic [15:0]       frame_length,
	output logic [1:0]        status,
	output logic              frame_end,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [15:0] max_len_q;
	logic        cfg_wr;
	logic        f_wr;
	rec_t        f_rec;
	logic        q_valid;
	rec_t        q_rec;
	logic        q_take;
	logic        out_valid;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr && (paddr[ADDR_W-1] == REG_MAX_LEN)) begin
			max_len_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[ADDR_W-1] == REG_MAX_LEN) ? {16'h0000, max_len_q} : '0;

	// Front: parse and classify.
	crcfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.max_len (max_len_q),
		.q_full  (full),
		.q_wr    (f_wr),
		.q_rec   (f_rec)
	);

	// Queue between the two sides.
	crcfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_wr),
		.wr_rec (f_rec),
		.full   (full),
		.rd     (q_take),
		.valid  (q_valid),
		.rd_rec (q_rec)
	);

	// Back: CRC and results.
	crcfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_rec         (q_rec),
		.q_take        (q_take),
		.pop           (pop),
		.out_valid     (out_valid),
		.data          (data),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.status        (status),
		.frame_end     (frame_end)
	);

	assign empty = !out_valid;

endmodule

// ===== hdl/crcfd_front.sv =====
// Front part: sync hunt, header parsing, length check and byte classification.
module crcfd_front import crcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_len,
	input  logic        q_full,
	output logic        q_wr,
	output rec_t        q_rec
);

	typedef enum logic [7:0] {
		PH_HUNT1   = 8'b0000_0001,
		PH_HUNT2   = 8'b0000_0010,
		PH_CMD     = 8'b0000_0100,
		PH_LEN_LO  = 8'b0000_1000,
		PH_LEN_HI  = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_CRC_LO  = 8'b0100_0000,
		PH_CRC_HI  = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q;
	logic [7:0]  len_lo_q;
	logic [15:0] len_q;
	logic [15:0] left_q;
	logic        accept;
	logic [15:0] new_len;
	logic        too_long;

	assign accept = push && !q_full;
	assign new_len = {rx_byte, len_lo_q};
	assign too_long = new_len > max_len;

	// Classify the accepted beat and choose the next phase.
	always_comb begin
		phase_d = phase_q;
		q_wr = 1'b0;
		q_rec.op = OP_FEED;
		q_rec.rx_val = rx_byte;
		q_rec.command = cmd_q;
		q_rec.length = len_q;
		case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == SYNC_FIRST) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (rx_byte == SYNC_SECOND) begin
					q_wr = accept;
					q_rec.op = OP_SYNC;
					phase_d = PH_CMD;
				end else if (rx_byte != SYNC_FIRST) begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CMD: begin
				q_wr = accept;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				q_wr = accept;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				q_wr = accept;
				q_rec.length = new_len;
				if (too_long) begin
					q_rec.op = OP_ABORT;
					phase_d = PH_HUNT1;
				end else if (new_len == 16'd0) begin
					phase_d = PH_CRC_LO;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				q_wr = accept;
				q_rec.op = OP_DATA;
				if (left_q == 16'd1) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				q_wr = accept;
				q_rec.op = OP_CRC_LO;
				phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				q_wr = accept;
				q_rec.op = OP_CHECK;
				phase_d = PH_HUNT1;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	// Phase register advances only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// Header fields and the payload countdown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= 8'h00;
			len_lo_q <= 8'h00;
			len_q <= 16'h0000;
			left_q <= 16'h0000;
		end else if (accept) begin
			if (phase_q == PH_CMD) cmd_q <= rx_byte;
			if (phase_q == PH_LEN_LO) begin
				len_lo_q <= rx_byte;
				len_q <= {8'h00, rx_byte};
			end
			if (phase_q == PH_LEN_HI) begin
				len_q <= new_len;
				left_q <= new_len;
			end
			if (phase_q == PH_PAYLOAD) left_q <= left_q - 16'd1;
		end
	end

endmodule

// ===== hdl/crcfd_queue.sv =====
// Short queue of classified beats between the front and the back.
module crcfd_queue import crcfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  rec_t wr_rec,
	output logic full,
	input  logic rd,
	output logic valid,
	output rec_t rd_rec
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full = count_q == QCNT_W'(QDEPTH);
	assign valid = count_q != '0;
	assign rd_rec = mem_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_rec;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + QCNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - QCNT_W'(1);
		end
	end

	// The fill count stays within the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	// A lone write grows the count by one.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue count did not grow on write");

	// A lone read shrinks the count by one.
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("queue count did not shrink on read");

endmodule

// ===== hdl/crcfd_back.sv =====
// Back part: CRC accumulation, frame check and the result register.
module crcfd_back import crcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  rec_t        q_rec,
	output logic        q_take,
	input  logic        pop,
	output logic        out_valid,
	output logic [7:0]  data,
	output logic [7:0]  frame_command,
	output logic [15:0] frame_length,
	output logic [1:0]  status,
	output logic        frame_end
);

	logic        out_valid_q;
	logic [7:0]  data_q;
	logic [7:0]  cmd_q;
	logic [15:0] len_q;
	logic [1:0]  status_q;
	logic        end_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic        emits;
	logic [15:0] crc_next;
	logic [1:0]  check_status;

	assign q_take = q_valid && (!out_valid_q || pop);
	assign emits = (q_rec.op == OP_DATA) || (q_rec.op == OP_ABORT) || (q_rec.op == OP_CHECK);
	assign crc_next = crc_feed(crc_q, q_rec.rx_val);
	assign check_status = ({q_rec.rx_val, crc_lo_q} == crc_q) ? ST_GOOD : ST_CRC_BAD;

	// Running CRC and the held low CRC byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 16'h0000;
			crc_lo_q <= 8'h00;
		end else if (q_take) begin
			case (q_rec.op)
				OP_SYNC: crc_q <= CRC_AFTER_SYNC;
				OP_FEED, OP_DATA, OP_ABORT: crc_q <= crc_next;
				OP_CRC_LO: crc_lo_q <= q_rec.rx_val;
				default: ;
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_take && emits) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload loads when a result beat is formed.
	always_ff @(posedge clk) begin
		if (q_take && emits) begin
			cmd_q <= q_rec.command;
			len_q <= q_rec.length;
			case (q_rec.op)
				OP_DATA: begin
					data_q <= q_rec.rx_val;
					status_q <= ST_GOOD;
					end_q <= 1'b0;
				end
				OP_ABORT: begin
					data_q <= 8'h00;
					status_q <= ST_TOO_LONG;
					end_q <= 1'b1;
				end
				default: begin
					data_q <= 8'h00;
					status_q <= check_status;
					end_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign data = data_q;
	assign frame_command = cmd_q;
	assign frame_length = len_q;
	assign status = status_q;
	assign frame_end = end_q;

	// A waiting result is never overwritten before it is popped.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(data_q) && $stable(status_q))
		else $error("result overwritten while waiting");

	// Payload beats always carry good status.
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !end_q |-> status_q == ST_GOOD)
		else $error("payload beat with nonzero status");

	// Closing beats carry zero data.
	a_end_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_q |-> data_q == 8'h00)
		else $error("closing beat with nonzero data");

endmodule
